[sv/gcd_pkg.sv]
package gcd_pkg;

   // Default operand width; the top level parameter may override it (2..64)
   localparam int OPERAND_WIDTH_DEFAULT = 32;

   // Result field width is fixed by the stream format
   localparam int DIVISOR_WIDTH = 32;

   // Result bus width, whole bytes
   localparam int RSP_DATA_WIDTH = ((DIVISOR_WIDTH + 7) / 8) * 8;

endpackage

[sv/gcd_step.sv]
module gcd_step #(
   parameter int OPERAND_WIDTH = gcd_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 prev_valid,
   input  logic [OPERAND_WIDTH-1:0]             prev_a,
   input  logic [OPERAND_WIDTH-1:0]             prev_b,
   input  logic [$clog2(OPERAND_WIDTH)-1:0]     prev_k,
   output logic                                 next_valid,
   output logic [OPERAND_WIDTH-1:0]             next_a,
   output logic [OPERAND_WIDTH-1:0]             next_b,
   output logic [$clog2(OPERAND_WIDTH)-1:0]     next_k
);

   localparam int KW = $clog2(OPERAND_WIDTH);

   logic                     valid_ff;
   logic [OPERAND_WIDTH-1:0] a_ff, a_in;
   logic [OPERAND_WIDTH-1:0] b_ff, b_in;
   logic [KW-1:0]            k_ff, k_in;
   logic [OPERAND_WIDTH:0]   diff_ab;
   logic [OPERAND_WIDTH-1:0] diff_ba;

   // One binary GCD step: strip a factor of two, or subtract odd from odd and halve the difference
   always_comb begin
      diff_ab = {1'b0, prev_a} - {1'b0, prev_b};
      diff_ba = prev_b - prev_a;
      a_in    = prev_a;
      b_in    = prev_b;
      k_in    = prev_k;
      if (prev_a == '0 || prev_b == '0) begin
         // finished: the nonzero operand carries the odd part
         a_in = prev_a;
      end else if (!prev_a[0] && !prev_b[0]) begin
         a_in = prev_a >> 1;
         b_in = prev_b >> 1;
         k_in = KW'(prev_k + 1'b1);
      end else if (!prev_a[0]) begin
         a_in = prev_a >> 1;
      end else if (!prev_b[0]) begin
         b_in = prev_b >> 1;
      end else if (!diff_ab[OPERAND_WIDTH]) begin
         a_in = diff_ab[OPERAND_WIDTH-1:0] >> 1;
      end else begin
         b_in = diff_ba >> 1;
      end
   end

   // Stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff <= a_in;
         b_ff <= b_in;
         k_ff <= k_in;
      end
   end

   assign next_valid = valid_ff;
   assign next_a     = a_ff;
   assign next_b     = b_ff;
   assign next_k     = k_ff;

endmodule

[sv/gcd_skid.sv]
module gcd_skid (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push_valid,
   input  logic [gcd_pkg::DIVISOR_WIDTH-1:0]     push_data,
   output logic                                  room,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [gcd_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata
);

   import gcd_pkg::*;

   logic                     out_valid_ff, out_valid_in;
   logic [DIVISOR_WIDTH-1:0] out_data_ff, out_data_in;
   logic                     spare_valid_ff, spare_valid_in;
   logic [DIVISOR_WIDTH-1:0] spare_data_ff, spare_data_in;
   logic                     pop;

   // Push is only offered while the spare slot is free
   assign room = !spare_valid_ff;
   assign pop  = out_valid_ff && rsp_tready;

   // Output register refills from the spare slot first, then from the pipe
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_data_in    = out_data_ff;
      spare_valid_in = spare_valid_ff;
      spare_data_in  = spare_data_ff;
      if (!out_valid_ff || pop) begin
         if (spare_valid_ff) begin
            out_valid_in   = 1'b1;
            out_data_in    = spare_data_ff;
            spare_valid_in = 1'b0;
         end else begin
            out_valid_in = push_valid;
            out_data_in  = push_data;
         end
      end else if (push_valid && !spare_valid_ff) begin
         spare_valid_in = 1'b1;
         spare_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         out_valid_ff   <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff   <= out_data_in;
      spare_data_ff <= spare_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'(out_data_ff);

endmodule

[sv/gcd_unit.sv]
// Path from accepted request beat to result beat: input register, one binary GCD step per stage, shift
// stage, output. Throughput: one beat per cycle while the output buffer has room;
// the 2*OPERAND_WIDTH step stages bound the work per item.
// Stalls back up through a two-entry output buffer; nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits; payload registers are not reset.
module gcd_unit #(
   parameter int OPERAND_WIDTH = gcd_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // [OW-1:0] first_operand, [2*OW-1:OW] second_operand, zero fill to bytes
   input  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0]          req_tdata,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // [31:0] divisor
   output logic [gcd_pkg::RSP_DATA_WIDTH-1:0]            rsp_tdata
);

   import gcd_pkg::*;

   localparam int KW        = $clog2(OPERAND_WIDTH);
   localparam int NUM_STEPS = 2 * OPERAND_WIDTH;

   logic                     advance;
   logic [OPERAND_WIDTH-1:0] first_operand;
   logic [OPERAND_WIDTH-1:0] second_operand;

   logic                     stage_valid [0:NUM_STEPS];
   logic [OPERAND_WIDTH-1:0] stage_a     [0:NUM_STEPS];
   logic [OPERAND_WIDTH-1:0] stage_b     [0:NUM_STEPS];
   logic [KW-1:0]            stage_k     [0:NUM_STEPS];

   logic                     entry_valid_ff;
   logic [OPERAND_WIDTH-1:0] entry_a_ff, entry_a_in;
   logic [OPERAND_WIDTH-1:0] entry_b_ff, entry_b_in;

   logic                     final_valid_ff;
   logic [DIVISOR_WIDTH-1:0] final_data_ff, final_data_in;
   logic [OPERAND_WIDTH-1:0] gcd_value;

   assign first_operand  = req_tdata[OPERAND_WIDTH-1:0];
   assign second_operand = req_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH];
   assign req_tready     = advance;

   // Entry: a zero operand becomes the pair (1, 0), which finishes as 1
   always_comb begin
      if (first_operand == '0 || second_operand == '0) begin
         entry_a_in = OPERAND_WIDTH'(1);
         entry_b_in = '0;
      end else begin
         entry_a_in = first_operand;
         entry_b_in = second_operand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_a_ff <= entry_a_in;
         entry_b_ff <= entry_b_in;
      end
   end

   assign stage_valid[0] = entry_valid_ff;
   assign stage_a[0]     = entry_a_ff;
   assign stage_b[0]     = entry_b_ff;
   assign stage_k[0]     = '0;

   // Step chain
   for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
      gcd_step #(
         .OPERAND_WIDTH(OPERAND_WIDTH)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .prev_valid (stage_valid[i]),
         .prev_a     (stage_a[i]),
         .prev_b     (stage_b[i]),
         .prev_k     (stage_k[i]),
         .next_valid (stage_valid[i+1]),
         .next_a     (stage_a[i+1]),
         .next_b     (stage_b[i+1]),
         .next_k     (stage_k[i+1])
      );
   end

   // Final: one operand is zero, restore the common power of two
   assign gcd_value     = (stage_a[NUM_STEPS] | stage_b[NUM_STEPS]) << stage_k[NUM_STEPS];
   assign final_data_in = DIVISOR_WIDTH'(gcd_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         final_valid_ff <= 1'b0;
      end else if (advance) begin
         final_valid_ff <= stage_valid[NUM_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         final_data_ff <= final_data_in;
      end
   end

   // Output buffer; its free slot gates the whole pipe
   gcd_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (final_valid_ff && advance),
      .push_data  (final_data_ff),
      .room       (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[tb/gcd_checker.sv]
module gcd_checker #(
   parameter int OPERAND_WIDTH = gcd_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   // [OW-1:0] first_operand, [2*OW-1:OW] second_operand, zero fill to bytes
   input  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] divisor
   input  logic [gcd_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   output int                                   mismatch_count,
   output int                                   divisors_due
);

   localparam int OW = OPERAND_WIDTH;
   localparam int DW = gcd_pkg::DIVISOR_WIDTH;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [OW-1:0] first_operand;
      logic [OW-1:0] second_operand;
      logic [DW-1:0] divisor;
   } gcd_case_type;

   // Divisors still owed by the block, oldest first
   gcd_case_type pending_divisors[$];

   // Euclid by remainders; a zero operand gives 1 instead of the textbook answer
   function automatic logic [DW-1:0] common_divisor(input logic [OW-1:0] a,
                                                    input logic [OW-1:0] b);
      logic [OW-1:0] x;
      logic [OW-1:0] y;
      logic [OW-1:0] r;
      if (a == '0 || b == '0) return DW'(1);
      x = a;
      y = b;
      while (y != '0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return DW'(x);
   endfunction

   // Score both channels at each rising edge
   always @(posedge clock) begin
      gcd_case_type owed;
      gcd_case_type fresh;
      if (!reset) begin
         // result beat: compare with the oldest owed divisor
         if (rsp_tvalid && rsp_tready) begin
            if (pending_divisors.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("gcd_checker: unexpected result beat, divisor %0d",
                           rsp_tdata[DW-1:0]);
            end else begin
               owed = pending_divisors.pop_front();
               if (rsp_tdata[DW-1:0] !== owed.divisor) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("gcd_checker: gcd(%0d, %0d) expected %0d, got %0d",
                              owed.first_operand, owed.second_operand,
                              owed.divisor, rsp_tdata[DW-1:0]);
               end
            end
         end
         // request beat: predict its divisor
         if (req_tvalid && req_tready) begin
            fresh.first_operand  = req_tdata[OW-1:0];
            fresh.second_operand = req_tdata[2*OW-1:OW];
            fresh.divisor        = common_divisor(fresh.first_operand,
                                                  fresh.second_operand);
            pending_divisors.push_back(fresh);
         end
      end
      divisors_due = pending_divisors.size();
   end

endmodule

[tb/tb.sv]
module tb;

   localparam int OW = gcd_pkg::OPERAND_WIDTH_DEFAULT;
   localparam int REQ_W = ((2*OW+7)/8)*8;
   localparam int LATENCY = 2*OW + 3;
   localparam int RANDOM_BEATS = 1100;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [OW-1:0] ALL_ONES = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [gcd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;

   int mismatch_count;
   int divisors_due;
   int cycle_count = 0;
   // when set, neither side inserts idle cycles
   logic steady = 1'b0;

   gcd_unit #(.OPERAND_WIDTH(OW)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   gcd_checker #(.OPERAND_WIDTH(OW)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .divisors_due   (divisors_due)
   );

   // 4-unit clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result side backpressure: ready dropped at random about 14% of the time unless steady
   always @(negedge clock) begin
      rsp_tready <= steady ? 1'b1 : ($urandom_range(99) >= 14);
   end

   // Present one operand pair; called and returns at a falling edge
   task automatic send_pair(input logic [OW-1:0] a, input logic [OW-1:0] b);
      logic [REQ_W-1:0] beat;
      while (!steady && $urandom_range(99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         @(negedge clock);
      end
      beat = '0;
      beat[OW-1:0] = a;
      beat[2*OW-1:OW] = b;
      req_tvalid <= 1'b1;
      req_tdata <= beat;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Random pair drawn from one of several shapes
   task automatic send_random_pair(input int idx);
      logic [OW-1:0] a;
      logic [OW-1:0] b;
      logic [OW-1:0] g;
      int shape;
      shape = $urandom_range(99);
      steady <= (idx >= 300 && idx < 550);
      if (shape < 30) begin
         // arbitrary operands, every bit exercised
         a = $urandom;
         b = $urandom;
      end else if (shape < 60) begin
         // shared factor
         g = ($urandom_range(1) == 1) ? OW'($urandom_range(1, 65535))
                                      : (OW'(1) << $urandom_range(0, 20));
         a = g * OW'($urandom_range(1, ALL_ONES / g));
         b = g * OW'($urandom_range(1, ALL_ONES / g));
      end else if (shape < 70) begin
         // many trailing zeros
         a = OW'($urandom) << $urandom_range(0, OW-1);
         b = OW'($urandom) << $urandom_range(0, OW-1);
      end else if (shape < 80) begin
         // zero operand on one or both sides
         a = $urandom;
         b = $urandom;
         case ($urandom_range(2))
            0: a = '0;
            1: b = '0;
            default: begin
               a = '0;
               b = '0;
            end
         endcase
      end else if (shape < 88) begin
         a = $urandom;
         b = a;
      end else if (shape < 94) begin
         a = $urandom_range(15);
         b = $urandom_range(15);
      end else begin
         // one operand a multiple of the other
         b = $urandom_range(1, 100000);
         a = b * OW'($urandom_range(1, ALL_ONES / b));
         if ($urandom_range(1) == 1) begin
            g = a;
            a = b;
            b = g;
         end
      end
      send_pair(a, b);
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: zero operands, extremes, equal, coprime, long Euclid chains
      send_pair('0, '0);
      send_pair('0, 5);
      send_pair(7, '0);
      send_pair('0, ALL_ONES);
      send_pair(ALL_ONES, '0);
      send_pair(ALL_ONES, ALL_ONES);
      send_pair(1, 1);
      send_pair(1, ALL_ONES);
      send_pair(ALL_ONES, 1);
      send_pair(12, 18);
      send_pair(17, 17);
      send_pair(13, 7);
      send_pair(32'h8000_0000, 32'h8000_0000);
      send_pair(32'h8000_0000, 32'hC000_0000);
      send_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_pair(32'h8000_0000, 32'hFFFF_FFFF);
      send_pair(48, 180);
      send_pair(1071, 462);
      send_pair(32'd2971215073, 32'd1836311903);
      send_pair(32'hAAAA_AAAA, 32'h5555_5555);
      send_pair(32'hFFFF_0000, 32'h0000_FFFF);
      send_pair(2, 4);

      // Hold off until the pipeline has drained completely
      req_tvalid <= 1'b0;
      while (divisors_due != 0) @(negedge clock);

      for (int i = 0; i < RANDOM_BEATS; i++) send_random_pair(i);
      req_tvalid <= 1'b0;
      steady <= 1'b0;

      while (divisors_due != 0) @(negedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
